[rtl/note_duration_tracker_top_defines.svh]
// ----------------------------------------------------------------------------
// Note duration tracker assertion macros
// Shared assertion macros for the note duration tracker RTL. Each macro
// expects a clock named clk and an active-low reset named arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef NOTE_DURATION_TRACKER_TOP_DEFINES_SVH
`define NOTE_DURATION_TRACKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define NDT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define NDT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define NDT_ASSERT(label, prop, msg)
`define NDT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/ndt_pkg.sv]
// ----------------------------------------------------------------------------
// Note duration tracker package
// Sizes, codes and beat types shared by the note duration tracker modules.
// ----------------------------------------------------------------------------
package ndt_pkg;

	localparam int SLOTS       = 32;
	localparam int CHANNELS    = 16;
	localparam int MAX_RESULTS = 32;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CHAN_W = 4;
	localparam int NOTE_W = 7;
	localparam int VEL_W  = 7;
	localparam int DUR_W  = 28;
	localparam int REM_W  = DUR_W + 1;
	localparam int CNT_W  = 8;
	localparam int NEXP_W = $clog2(MAX_RESULTS + 1);

	localparam logic OP_NOTE_ON = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	localparam logic KIND_ON  = 1'b0;
	localparam logic KIND_OFF = 1'b1;

	typedef struct packed {
		logic              op;
		logic [CHAN_W-1:0] channel;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  velocity;
		logic [DUR_W-1:0]  duration;
	} item_t;

	typedef struct packed {
		logic              kind;
		logic [CHAN_W-1:0] out_channel;
		logic [NOTE_W-1:0] out_note;
		logic [VEL_W-1:0]  out_velocity;
		logic [CNT_W-1:0]  channel_active;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [NOTE_W-1:0] note;
		logic [REM_W-1:0]  remaining;
	} slot_t;

	typedef struct packed {
		logic              note_on;
		logic              walk_start;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              flush;
	} ndt_cmd_t;

endpackage

[rtl/ndt_ctrl.sv]
// ----------------------------------------------------------------------------
// Note duration tracker controller
// Accepts commands, sequences the slot walk of a tick and drives the
// datapath through a command bundle.
// ----------------------------------------------------------------------------
`include "note_duration_tracker_top_defines.svh"

module ndt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             op,
	output logic             busy,
	output ndt_pkg::ndt_cmd_t cmd
);
	import ndt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DRAIN,
		S_FLUSH
	} state_t;

	state_t            state_q;
	logic              busy_q;
	logic [SLOT_W-1:0] rd_idx_q;
	logic              accept;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_comb begin
		cmd            = '0;
		cmd.note_on    = accept && (op == OP_NOTE_ON);
		cmd.walk_start = accept && (op == OP_TICK);
		cmd.rd_en      = (state_q == S_WALK);
		cmd.rd_addr    = rd_idx_q;
		cmd.flush      = (state_q == S_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			busy_q   <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (op == OP_TICK)) begin
						state_q  <= S_WALK;
						busy_q   <= 1'b1;
						rd_idx_q <= '0;
					end
				end
				S_WALK: begin
					if (rd_idx_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	`NDT_ASSERT(a_busy_matches_state, busy_q == (state_q != S_IDLE), "busy out of step with state")
	`NDT_ASSERT_NEXT(a_flush_ends_walk, state_q == S_FLUSH, state_q == S_IDLE && !busy_q, "walk did not end after flush")

endmodule

[rtl/ndt_dp.sv]
// ----------------------------------------------------------------------------
// Note duration tracker datapath
// Holds the slot memory, occupancy bits, per-channel note counts and the
// lock register, and forms the outgoing note-on and note-off beats.
// ----------------------------------------------------------------------------
`include "note_duration_tracker_top_defines.svh"

module ndt_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ndt_pkg::ndt_cmd_t         cmd,
	input  ndt_pkg::item_t            item,
	input  logic                      cfg_we,
	input  logic [ndt_pkg::CHANNELS-1:0] cfg_data,
	output ndt_pkg::result_t          result,
	output logic                      result_strobe
);
	import ndt_pkg::*;

	slot_t             slot_mem [SLOTS];
	slot_t             rd_data_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic              vld_s1;

	logic [SLOTS-1:0]    occ_q;
	logic [CNT_W-1:0]    cnt_q [CHANNELS];
	logic [CHANNELS-1:0] locked_q;
	logic [NEXP_W-1:0]   nexp_q;
	logic                pend_vld_q;
	result_t             pend_q;
	result_t             result_q;
	logic                result_strobe_q;

	logic              free_found;
	logic [SLOT_W-1:0] free_idx;
	logic [SLOT_W-1:0] on_slot;
	logic              on_take;
	logic [CHAN_W-1:0] cnt_addr;
	logic [CNT_W-1:0]  cnt_rd;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  cnt_dec;
	logic              proc;
	logic [REM_W-1:0]  rem_dec;
	logic              expire;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	slot_t             wr_data;
	result_t           on_res;
	result_t           off_res;
	result_t           pend_out;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign on_slot  = free_found ? free_idx : '0;
	assign on_take  = cmd.note_on && !locked_q[item.channel];
	assign cnt_addr = vld_s1 ? rd_data_s1.channel : item.channel;
	assign cnt_rd   = cnt_q[cnt_addr];
	assign cnt_inc  = cnt_rd + 1'b1;
	assign cnt_dec  = cnt_rd - 1'b1;

	assign proc    = vld_s1 && occ_q[idx_s1] && (nexp_q < NEXP_W'(MAX_RESULTS));
	assign rem_dec = rd_data_s1.remaining - 1'b1;
	assign expire  = proc && rem_dec[REM_W-1];

	always_comb begin
		wr_en   = on_take || proc;
		wr_addr = on_take ? on_slot : idx_s1;
		if (on_take) begin
			wr_data.channel   = item.channel;
			wr_data.note      = item.note;
			wr_data.remaining = {1'b0, item.duration} - 1'b1;
		end else begin
			wr_data.channel   = rd_data_s1.channel;
			wr_data.note      = rd_data_s1.note;
			wr_data.remaining = rem_dec;
		end
	end

	always_comb begin
		on_res.kind           = KIND_ON;
		on_res.out_channel    = item.channel;
		on_res.out_note       = item.note;
		on_res.out_velocity   = item.velocity;
		on_res.channel_active = cnt_inc;
		on_res.last           = 1'b1;

		off_res.kind           = KIND_OFF;
		off_res.out_channel    = rd_data_s1.channel;
		off_res.out_note       = rd_data_s1.note;
		off_res.out_velocity   = '0;
		off_res.channel_active = cnt_dec;
		off_res.last           = 1'b0;

		pend_out      = pend_q;
		pend_out.last = cmd.flush;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= slot_mem[cmd.rd_addr];
			idx_s1     <= cmd.rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (on_take) begin
			result_q <= on_res;
		end else if ((expire || cmd.flush) && pend_vld_q) begin
			result_q <= pend_out;
		end
		if (expire) begin
			pend_q <= off_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q           <= '0;
			cnt_q           <= '{default: '0};
			locked_q        <= '0;
			nexp_q          <= '0;
			pend_vld_q      <= 1'b0;
			vld_s1          <= 1'b0;
			result_strobe_q <= 1'b0;
		end else begin
			vld_s1          <= cmd.rd_en;
			result_strobe_q <= on_take || ((expire || cmd.flush) && pend_vld_q);
			if (cfg_we) begin
				locked_q <= cfg_data;
			end
			if (cmd.walk_start) begin
				nexp_q     <= '0;
				pend_vld_q <= 1'b0;
			end
			if (on_take) begin
				occ_q[on_slot]        <= 1'b1;
				cnt_q[cnt_addr]       <= cnt_inc;
			end
			if (expire) begin
				occ_q[idx_s1]   <= 1'b0;
				cnt_q[cnt_addr] <= cnt_dec;
				nexp_q          <= nexp_q + 1'b1;
				pend_vld_q      <= 1'b1;
			end
			if (cmd.flush && pend_vld_q) begin
				pend_vld_q      <= 1'b0;
			end
		end
	end

	assign result        = result_q;
	assign result_strobe = result_strobe_q;

	`NDT_ASSERT(a_nexp_bound, nexp_q <= NEXP_W'(MAX_RESULTS), "note-off count past limit")
	`NDT_ASSERT(a_noteon_last, result_strobe_q && result_q.kind == KIND_ON |-> result_q.last, "note-on beat not marked last")
	`NDT_ASSERT(a_no_noteon_in_walk, !(on_take && vld_s1), "note-on taken during slot walk")

endmodule

[rtl/note_duration_tracker_top.sv]
// ----------------------------------------------------------------------------
// Note duration tracker
// Table of sounding notes with remaining durations, emitting note-on and
// note-off beats.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low. A note-on
//   item on an unlocked channel takes the lowest free slot (slot 0 when the
//   table is full) and produces one note-on beat in the next cycle; busy stays
//   low, so note-on items may follow every cycle. A note-on on a locked
//   channel produces nothing.
//   A tick item raises busy through the WALK, DRAIN and FLUSH states: the
//   controller reads one slot per cycle from the slot memory, the datapath
//   decrements it in the next cycle and writes it back. Note-off beats appear
//   during the walk and the final one, marked last, in the cycle busy falls.
//   A tick that frees nothing produces no beat.
//   Every result beat is on result for one cycle with result_strobe high; the
//   receiver must take it then, it cannot stall the block.
//   The lock register is written through cfg_valid / cfg_data; write it only
//   while idle, as the block does not enforce this. cfg_ready is always high.
//   Reset marks every slot free, zeroes the channel counts and the lock mask.
// ----------------------------------------------------------------------------
module note_duration_tracker_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  ndt_pkg::item_t               item,
	output ndt_pkg::result_t             result,
	output logic                         result_strobe,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ndt_pkg::CHANNELS-1:0] cfg_data
);
	import ndt_pkg::*;

	ndt_cmd_t cmd;
	logic     cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	ndt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (item.op),
		.busy   (busy),
		.cmd    (cmd)
	);

	ndt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item          (item),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

[test/note_duration_tracker_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Note duration tracker testbench
// Drives note-on and tick items into the tracker with random gaps and
// compares every note-on and note-off beat with a model of the note table.
// A short table of directed items comes first. Random phases follow under
// several lock masks, including a table overflow.
// ----------------------------------------------------------------------------
module note_duration_tracker_top_tb;
	import ndt_pkg::*;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_ONE} row_check_t;

	typedef struct packed {
		item_t      beat;
		row_check_t check;
		result_t    want;
	} directed_row_t;

	localparam int SETTLE_CYCLES = SLOTS + 11;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	item_t               item_beat = '0;
	result_t             result_beat;
	logic                result_strobe;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CHANNELS-1:0] cfg_data = '0;

	logic                slot_used [SLOTS];
	logic [CHAN_W-1:0]   slot_chan [SLOTS];
	logic [NOTE_W-1:0]   slot_note [SLOTS];
	int                  slot_left [SLOTS];
	logic [CNT_W-1:0]    chan_count [CHANNELS];
	logic [CHANNELS-1:0] lock_mask;

	result_t item_msgs [$];
	result_t due_msgs [$];

	int items_taken = 0;
	int lock_writes = 0;
	int overflows = 0;
	int count_wraps = 0;
	int biggest_tick = 0;
	int ons_seen = 0;
	int offs_seen = 0;
	int mismatches = 0;
	int calm_left = 0;

	directed_row_t directed_rows [15] = '{
		'{'{OP_NOTE_ON, 4'd0, 7'd0, 7'd0, 28'hFFFFFFF}, ROW_ONE,
			'{KIND_ON, 4'd0, 7'd0, 7'd0, 8'd1, 1'b1}},
		'{'{OP_NOTE_ON, 4'd15, 7'd127, 7'd127, 28'd0}, ROW_ONE,
			'{KIND_ON, 4'd15, 7'd127, 7'd127, 8'd1, 1'b1}},
		'{'{OP_TICK, 4'd0, 7'd0, 7'd0, 28'd0}, ROW_ONE,
			'{KIND_OFF, 4'd15, 7'd127, 7'd0, 8'd0, 1'b1}},
		'{'{OP_TICK, 4'd15, 7'd127, 7'd127, 28'hFFFFFFF}, ROW_NONE, '0},
		'{'{OP_NOTE_ON, 4'd14, 7'd64, 7'd64, 28'd5}, ROW_NONE, '0},
		'{'{OP_NOTE_ON, 4'd3, 7'd60, 7'd100, 28'd1}, ROW_ONE,
			'{KIND_ON, 4'd3, 7'd60, 7'd100, 8'd1, 1'b1}},
		'{'{OP_NOTE_ON, 4'd3, 7'd64, 7'd90, 28'd2}, ROW_PREDICT, '0},
		'{'{OP_NOTE_ON, 4'd3, 7'd67, 7'd80, 28'd1}, ROW_PREDICT, '0},
		'{'{OP_NOTE_ON, 4'd9, 7'd36, 7'd127, 28'd3}, ROW_PREDICT, '0},
		'{'{OP_TICK, 4'd0, 7'd0, 7'd0, 28'd0}, ROW_PREDICT, '0},
		'{'{OP_TICK, 4'd0, 7'd0, 7'd0, 28'd0}, ROW_PREDICT, '0},
		'{'{OP_TICK, 4'd0, 7'd0, 7'd0, 28'd0}, ROW_PREDICT, '0},
		'{'{OP_NOTE_ON, 4'd5, 7'h55, 7'h2A, 28'd0}, ROW_PREDICT, '0},
		'{'{OP_NOTE_ON, 4'd10, 7'h2A, 7'h55, 28'd0}, ROW_PREDICT, '0},
		'{'{OP_TICK, 4'd0, 7'd0, 7'd0, 28'd0}, ROW_PREDICT, '0}
	};

	note_duration_tracker_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item_beat),
		.result        (result_beat),
		.result_strobe (result_strobe),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Applies one item to the note table and leaves the beats it causes in item_msgs.
	function automatic void apply_to_note_table(input item_t it);
		int      slot;
		int      sent;
		result_t msg;
		item_msgs.delete();
		if (it.op == OP_NOTE_ON) begin
			if (lock_mask[it.channel])
				return;
			slot = -1;
			for (int i = 0; i < SLOTS; i++)
				if (!slot_used[i] && slot < 0)
					slot = i;
			if (slot < 0) begin
				slot = 0;
				overflows++;
			end
			slot_used[slot] = 1'b1;
			slot_chan[slot] = it.channel;
			slot_note[slot] = it.note;
			slot_left[slot] = int'(it.duration) - 1;
			chan_count[it.channel] = chan_count[it.channel] + 8'd1;
			if (chan_count[it.channel] == '0)
				count_wraps++;
			msg.kind = KIND_ON;
			msg.out_channel = it.channel;
			msg.out_note = it.note;
			msg.out_velocity = it.velocity;
			msg.channel_active = chan_count[it.channel];
			msg.last = 1'b1;
			item_msgs.push_back(msg);
		end else begin
			sent = 0;
			for (int i = 0; i < SLOTS && sent < MAX_RESULTS; i++) begin
				if (slot_used[i]) begin
					slot_left[i] = slot_left[i] - 1;
					if (slot_left[i] < 0) begin
						slot_used[i] = 1'b0;
						if (chan_count[slot_chan[i]] == '0)
							count_wraps++;
						chan_count[slot_chan[i]] = chan_count[slot_chan[i]] - 8'd1;
						msg.kind = KIND_OFF;
						msg.out_channel = slot_chan[i];
						msg.out_note = slot_note[i];
						msg.out_velocity = '0;
						msg.channel_active = chan_count[slot_chan[i]];
						msg.last = 1'b0;
						item_msgs.push_back(msg);
						sent++;
					end
				end
			end
			if (sent > 0)
				item_msgs[sent - 1].last = 1'b1;
			if (sent > biggest_tick)
				biggest_tick = sent;
		end
	endfunction

	function automatic item_t random_beat(input int tick_pct);
		item_t it;
		int    pick;
		it.op = ($urandom_range(1, 100) <= tick_pct) ? OP_TICK : OP_NOTE_ON;
		it.channel = CHAN_W'($urandom_range(0, CHANNELS - 1));
		it.note = NOTE_W'($urandom_range(0, 127));
		it.velocity = VEL_W'($urandom_range(0, 127));
		pick = $urandom_range(0, 99);
		if (pick < 70)
			it.duration = DUR_W'($urandom_range(0, 3));
		else if (pick < 95)
			it.duration = DUR_W'($urandom_range(4, 20));
		else
			it.duration = DUR_W'($urandom_range(21, 60));
		return it;
	endfunction

	task automatic pause();
		int gap;
		int pick;
		gap = 0;
		if (calm_left > 0) begin
			calm_left--;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 2)
				calm_left = $urandom_range(10, 30);
			else if (pick < 60)
				gap = 0;
			else if (pick < 90)
				gap = $urandom_range(1, 3);
			else if (pick < 97)
				gap = $urandom_range(4, 12);
			else
				gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue(input item_t it, input row_check_t check, input result_t want);
		start <= 1'b1;
		item_beat <= it;
		do @(posedge clk); while (busy);
		apply_to_note_table(it);
		items_taken++;
		case (check)
			ROW_PREDICT: begin
				foreach (item_msgs[k])
					due_msgs.push_back(item_msgs[k]);
			end
			ROW_ONE: begin
				due_msgs.push_back(want);
			end
			default: begin
			end
		endcase
		pause();
	endtask

	task automatic settle();
		start <= 1'b0;
		while (due_msgs.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_lock(input logic [CHANNELS-1:0] mask);
		cfg_valid <= 1'b1;
		cfg_data <= mask;
		do @(posedge clk); while (!cfg_ready);
		lock_mask = mask;
		lock_writes++;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_mixed(input int count, input int tick_pct);
		for (int n = 0; n < count; n++)
			issue(random_beat(tick_pct), ROW_PREDICT, '0);
	endtask

	task automatic flood(input int notes, input int ticks, input bit one_chan,
			input logic [CHAN_W-1:0] chan, input int dur_lo, input int dur_hi);
		item_t it;
		for (int n = 0; n < notes; n++) begin
			it = random_beat(0);
			if (one_chan)
				it.channel = chan;
			it.duration = DUR_W'($urandom_range(dur_lo, dur_hi));
			issue(it, ROW_PREDICT, '0);
		end
		for (int n = 0; n < ticks; n++)
			issue(random_beat(100), ROW_PREDICT, '0);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_strobe) begin
			if (result_beat.kind == KIND_ON)
				ons_seen++;
			else
				offs_seen++;
			if (due_msgs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected beat at %0t: kind %0d ch %0d note %0d vel %0d cnt %0d last %0d",
						$realtime, result_beat.kind, result_beat.out_channel,
						result_beat.out_note, result_beat.out_velocity,
						result_beat.channel_active, result_beat.last);
			end else begin
				want = due_msgs.pop_front();
				if (result_beat.kind !== want.kind ||
						result_beat.out_channel !== want.out_channel ||
						result_beat.out_note !== want.out_note ||
						result_beat.out_velocity !== want.out_velocity ||
						result_beat.channel_active !== want.channel_active ||
						result_beat.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("Mismatch at %0t: expected kind %0d ch %0d note %0d vel %0d",
							$realtime, want.kind, want.out_channel, want.out_note,
							want.out_velocity);
						$write(" cnt %0d last %0d, got kind %0d ch %0d note %0d",
							want.channel_active, want.last, result_beat.kind,
							result_beat.out_channel, result_beat.out_note);
						$display(" vel %0d cnt %0d last %0d", result_beat.out_velocity,
							result_beat.channel_active, result_beat.last);
					end
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_chan[i] = '0;
			slot_note[i] = '0;
			slot_left[i] = 0;
		end
		foreach (chan_count[c])
			chan_count[c] = '0;
		lock_mask = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_lock(16'h4000);
		foreach (directed_rows[r])
			issue(directed_rows[r].beat, directed_rows[r].check, directed_rows[r].want);
		settle();

		write_lock('1);
		run_mixed(25, 30);
		settle();

		write_lock('0);
		run_mixed(70, 30);
		settle();

		write_lock(CHANNELS'($urandom));
		run_mixed(60, 35);
		settle();

		// Overfill the table so later note-ons land on slot 0.
		write_lock('0);
		flood(36, 4, 1'b0, '0, 3, 9);
		settle();

		$display("Ran %0d items under %0d lock masks: %0d note-on and %0d note-off beats.",
			items_taken, lock_writes, ons_seen, offs_seen);
		$display("Slot 0 overwrites: %0d, count wraps: %0d, most note-offs in one tick: %0d.",
			overflows, count_wraps, biggest_tick);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d beats still due.", due_msgs.size());
		$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/ndt_pkg.sv
rtl/ndt_ctrl.sv
rtl/ndt_dp.sv
rtl/note_duration_tracker_top.sv
test/note_duration_tracker_top_tb.sv
